// ===== rtl/core/cdsp_pkg.sv =====
// Shared constants, types and helpers for the point cloud depth splat block.
// No dependencies; every other file in rtl/core except cdsp_if imports this package.
package cdsp_pkg;

	localparam int ImgW    = 640;
	localparam int ImgH    = 480;
	localparam int Pixels  = ImgW * ImgH;
	localparam int IdxW    = $clog2(Pixels);
	localparam int ColW    = 10;
	localparam int RowW    = 9;
	localparam int HW      = 50;
	localparam int MagW    = HW - 1;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAT_X_LO,
		REG_MAT_X_HI,
		REG_MAT_Y_LO,
		REG_MAT_Y_HI,
		REG_MAT_Z_LO,
		REG_MAT_Z_HI,
		REG_CENTER_XY,
		REG_CENTER_Z
	} cfg_reg_t;

	typedef enum logic {
		REQ_SPLAT = 1'b0,
		REQ_READ  = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ACC,
		F_START,
		F_WAIT,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_UPDATE
	} back_state_t;

	// classified request handed from front to back
	typedef struct packed {
		logic            is_read;
		logic            hit;
		logic [IdxW-1:0] idx;
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic [31:0]     distance;
	} cmd_t;

	typedef struct packed {
		logic            written;
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic [31:0]     value;
		logic            valid;
	} res_t;

	function automatic logic signed [32:0] sx33(input logic [31:0] w);
		sx33 = {w[31], w};
	endfunction

	function automatic logic signed [HW-1:0] sx_hw(input logic [31:0] w);
		sx_hw = {{(HW-32){w[31]}}, w};
	endfunction

endpackage

// ===== rtl/core/cdsp_if.sv =====
// Valid/ready channel interfaces for the point cloud depth splat block.
// No dependencies.
interface cdsp_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [9:0]         read_col;
	logic [8:0]         read_row;

	modport source(output valid, req_type, point_x, point_y, point_z, read_col, read_row,
		input ready);
	modport sink(input valid, req_type, point_x, point_y, point_z, read_col, read_row,
		output ready);
endinterface

interface cdsp_out_if;
	logic        valid;
	logic        ready;
	logic        written;
	logic [9:0]  pixel_col;
	logic [8:0]  pixel_row;
	logic [31:0] depth_value;
	logic        depth_valid;

	modport source(output valid, written, pixel_col, pixel_row, depth_value, depth_valid,
		input ready);
	modport sink(input valid, written, pixel_col, pixel_row, depth_value, depth_valid,
		output ready);
endinterface

// ===== rtl/core/cdsp_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on cdsp_pkg.
module cdsp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cdsp_pkg::MagW-1:0] num,
	input  logic [cdsp_pkg::MagW-1:0] den,
	output logic [cdsp_pkg::MagW-1:0] quo,
	output logic                      done
);
	import cdsp_pkg::*;

	localparam int CntW = $clog2(MagW + 1);

	logic [MagW-1:0] num_q, den_q, quo_q;
	logic [MagW:0]   rem_q, rem_sh;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, done_q;

	assign rem_sh = {rem_q[MagW-1:0], num_q[MagW-1]};
	assign quo    = quo_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntW'(MagW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[MagW-2:0], 1'b0};
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[MagW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[MagW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/cdsp_isqrt.sv =====
// Digit-by-digit floor square root of a 64-bit value, two bits per cycle.
// Depends on cdsp_pkg.
module cdsp_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic [31:0] root,
	output logic        done
);
	import cdsp_pkg::*;

	logic [63:0] n_q;
	logic [31:0] root_q;
	logic [34:0] rem_q, rem_sh, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign rem_sh = {rem_q[32:0], n_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign root   = root_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/cdsp_front.sv =====
// Front end: config registers, projection and distance, pixel classification.
// Depends on cdsp_pkg, cdsp_if, cdsp_div and cdsp_isqrt.
module cdsp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	cdsp_in_if.sink                       request,
	input  logic                          cfg_we,
	input  logic [cdsp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [63:0]                   cfg_wdata,
	input  logic                          clr_busy,
	input  logic                          fifo_full,
	output logic                          push,
	output cdsp_pkg::cmd_t                cmd
);
	import cdsp_pkg::*;

	localparam logic [3:0] LastStep = 4'd11;

	front_state_t state_q, state_d;
	logic [3:0]   step_q;
	logic         accept, start;

	logic [63:0] mat_xl_q, mat_xh_q, mat_yl_q, mat_yh_q, mat_zl_q, mat_zh_q, cxy_q;
	logic [31:0] cz_q;

	logic               req_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [ColW-1:0]    rcol_q;
	logic [RowW-1:0]    rrow_q;

	logic signed [32:0]   mul_a, mul_b;
	logic signed [65:0]   prod_q;
	logic signed [HW-1:0] term, hx_q, hy_q, hz_q;
	logic [65:0]          sq_q;

	logic [HW-1:0]   absx, absy, absz;
	logic [MagW-1:0] qx, qy;
	logic            dx_done, dy_done, sq_done;
	logic [63:0]     rad;
	logic [31:0]     root;

	logic            okx, oky, hit_s, hit_r;
	logic [ColW-1:0] col;
	logic [RowW-1:0] row;

	assign accept = request.valid && request.ready;
	assign term   = prod_q[65:16];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_xl_q <= '0;
			mat_xh_q <= '0;
			mat_yl_q <= '0;
			mat_yh_q <= '0;
			mat_zl_q <= '0;
			mat_zh_q <= '0;
			cxy_q    <= '0;
			cz_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAT_X_LO:  mat_xl_q <= cfg_wdata;
				REG_MAT_X_HI:  mat_xh_q <= cfg_wdata;
				REG_MAT_Y_LO:  mat_yl_q <= cfg_wdata;
				REG_MAT_Y_HI:  mat_yh_q <= cfg_wdata;
				REG_MAT_Z_LO:  mat_zl_q <= cfg_wdata;
				REG_MAT_Z_HI:  mat_zh_q <= cfg_wdata;
				REG_CENTER_XY: cxy_q    <= cfg_wdata;
				REG_CENTER_Z:  cz_q     <= cfg_wdata[31:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				step_q <= '0;
			else if (state_q == F_ACC)
				step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (accept)
				state_d = (req_t'(request.req_type) == REQ_READ) ? F_PUSH : F_MUL;
			F_MUL:   state_d = F_ACC;
			F_ACC:   state_d = (step_q == LastStep) ? F_START : F_MUL;
			F_START: state_d = F_WAIT;
			F_WAIT:  if (dx_done && dy_done && sq_done) state_d = F_PUSH;
			F_PUSH:  if (!fifo_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		request.ready = (state_q == F_IDLE) && !clr_busy;
		start         = (state_q == F_START);
		push          = (state_q == F_PUSH) && !fifo_full;
	end

	// one shared multiplier, one product per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			4'd0:  begin mul_a = sx33(mat_xl_q[31:0]);  mul_b = sx33(px_q); end
			4'd1:  begin mul_a = sx33(mat_xl_q[63:32]); mul_b = sx33(py_q); end
			4'd2:  begin mul_a = sx33(mat_xh_q[31:0]);  mul_b = sx33(pz_q); end
			4'd3:  begin mul_a = sx33(mat_yl_q[31:0]);  mul_b = sx33(px_q); end
			4'd4:  begin mul_a = sx33(mat_yl_q[63:32]); mul_b = sx33(py_q); end
			4'd5:  begin mul_a = sx33(mat_yh_q[31:0]);  mul_b = sx33(pz_q); end
			4'd6:  begin mul_a = sx33(mat_zl_q[31:0]);  mul_b = sx33(px_q); end
			4'd7:  begin mul_a = sx33(mat_zl_q[63:32]); mul_b = sx33(py_q); end
			4'd8:  begin mul_a = sx33(mat_zh_q[31:0]);  mul_b = sx33(pz_q); end
			4'd9:  begin
				mul_a = sx33(cxy_q[31:0]) - sx33(px_q);
				mul_b = mul_a;
			end
			4'd10: begin
				mul_a = sx33(cxy_q[63:32]) - sx33(py_q);
				mul_b = mul_a;
			end
			4'd11: begin
				mul_a = sx33(cz_q) - sx33(pz_q);
				mul_b = mul_a;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= request.req_type;
			px_q   <= request.point_x;
			py_q   <= request.point_y;
			pz_q   <= request.point_z;
			rcol_q <= request.read_col;
			rrow_q <= request.read_row;
			hx_q   <= sx_hw(mat_xh_q[63:32]);
			hy_q   <= sx_hw(mat_yh_q[63:32]);
			hz_q   <= sx_hw(mat_zh_q[63:32]);
			sq_q   <= '0;
		end
		if (state_q == F_MUL)
			prod_q <= mul_a * mul_b;
		if (state_q == F_ACC) begin
			priority if (step_q < 4'd3)
				hx_q <= hx_q + term;
			else if (step_q < 4'd6)
				hy_q <= hy_q + term;
			else if (step_q < 4'd9)
				hz_q <= hz_q + term;
			else
				sq_q <= sq_q + $unsigned(prod_q);
		end
	end

	assign absx = hx_q[HW-1] ? -hx_q : hx_q;
	assign absy = hy_q[HW-1] ? -hy_q : hy_q;
	assign absz = hz_q[HW-1] ? -hz_q : hz_q;
	// a sum of squares past 64 bits saturates; its root is then all ones
	assign rad  = (sq_q[65:64] != 2'b00) ? '1 : sq_q[63:0];

	cdsp_div u_div_x (
		.clk, .arst_n, .start,
		.num(absx[MagW-1:0]), .den(absz[MagW-1:0]), .quo(qx), .done(dx_done)
	);

	cdsp_div u_div_y (
		.clk, .arst_n, .start,
		.num(absy[MagW-1:0]), .den(absz[MagW-1:0]), .quo(qy), .done(dy_done)
	);

	cdsp_isqrt u_isqrt (
		.clk, .arst_n, .start, .rad, .root, .done(sq_done)
	);

	// truncated quotient is positive only when signs agree and magnitude is nonzero
	always_comb begin
		okx   = (hx_q[HW-1] == hz_q[HW-1]) && (qx != '0) && (qx < MagW'(ImgW));
		oky   = (hy_q[HW-1] == hz_q[HW-1]) && (qy != '0) && (qy < MagW'(ImgH));
		hit_s = (hz_q != '0) && okx && oky;
		hit_r = (32'(rcol_q) < ImgW) && (32'(rrow_q) < ImgH);
		if (req_t'(req_q) == REQ_READ) begin
			col          = rcol_q;
			row          = rrow_q;
			cmd.is_read  = 1'b1;
			cmd.hit      = hit_r;
			cmd.distance = '0;
		end else begin
			col          = hit_s ? qx[ColW-1:0] : '0;
			row          = hit_s ? qy[RowW-1:0] : '0;
			cmd.is_read  = 1'b0;
			cmd.hit      = hit_s;
			cmd.distance = root;
		end
		cmd.col = col;
		cmd.row = row;
		cmd.idx = cmd.hit ? IdxW'(IdxW'(row) * IdxW'(ImgW) + IdxW'(col)) : '0;
	end
endmodule

// ===== rtl/core/cdsp_fifo.sv =====
// Two-entry command queue between front end and depth store.
// Depends on cdsp_pkg.
module cdsp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdsp_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output cdsp_pkg::cmd_t dout,
	output logic           empty
);
	import cdsp_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= din;
	end
endmodule

// ===== rtl/core/cdsp_back.sv =====
// Back end: depth store memory with fill flags, read-modify-write and result register.
// Depends on cdsp_pkg and cdsp_if.
module cdsp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fifo_empty,
	input  cdsp_pkg::cmd_t cmd,
	output logic           pop,
	output logic           clr_busy,
	cdsp_out_if.source     result
);
	import cdsp_pkg::*;

	// entry: {filled, distance}
	logic [32:0] depth_mem [Pixels];

	back_state_t     state_q, state_d;
	logic [IdxW-1:0] clr_cnt_q;
	cmd_t            cmd_q;
	logic [32:0]     rd_q;
	logic            ov_q;
	res_t            res_q, res_d;

	logic            mem_we;
	logic [IdxW-1:0] mem_waddr;
	logic [32:0]     mem_wdata;
	logic            closer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_cnt_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == B_UPDATE)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR:  if (clr_cnt_q == IdxW'(Pixels - 1)) state_d = B_IDLE;
			B_IDLE:   if (!fifo_empty && !ov_q) state_d = B_UPDATE;
			B_UPDATE: state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == B_IDLE) && !fifo_empty && !ov_q;
		clr_busy  = (state_q == B_CLEAR);
		closer    = !rd_q[32] || (cmd_q.distance < rd_q[31:0]);
		mem_we    = 1'b0;
		mem_waddr = cmd_q.idx;
		mem_wdata = {1'b1, cmd_q.distance};
		res_d.written = 1'b0;
		res_d.col     = cmd_q.col;
		res_d.row     = cmd_q.row;
		res_d.value   = cmd_q.distance;
		res_d.valid   = 1'b1;
		unique case (state_q)
			B_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			B_UPDATE: begin
				if (cmd_q.is_read) begin
					mem_we      = cmd_q.hit && rd_q[32];
					mem_wdata   = {1'b0, rd_q[31:0]};
					res_d.valid = cmd_q.hit && rd_q[32];
					res_d.value = res_d.valid ? rd_q[31:0] : '0;
				end else begin
					mem_we        = cmd_q.hit && (cmd_q.distance != '0) && closer;
					res_d.written = mem_we;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			depth_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q  <= depth_mem[cmd.idx];
			cmd_q <= cmd;
		end
		if (state_q == B_UPDATE)
			res_q <= res_d;
	end

	always_comb begin
		result.valid       = ov_q;
		result.written     = res_q.written;
		result.pixel_col   = res_q.col;
		result.pixel_row   = res_q.row;
		result.depth_value = res_q.value;
		result.depth_valid = res_q.valid;
	end

`ifndef SYNTH
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !ov_q)
		else $error("command popped while result register occupied");
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPDATE && cmd_q.is_read) |-> !(mem_we && mem_wdata[32]))
		else $error("read transaction set a fill flag");
	a_update_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPDATE) |=> ov_q)
		else $error("update did not load the result register");
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !ov_q)
		else $error("result during clearing pass");
`endif
endmodule

// ===== rtl/core/point_cloud_depth_splat.sv =====
// Top level of the point cloud depth splat block: front end, queue, depth store.
// Depends on cdsp_pkg, cdsp_if, cdsp_front, cdsp_fifo and cdsp_back.
//
//   channel   dir   handshake      payload
//   request   in    valid/ready    req_type, point_x/y/z, read_col, read_row
//   result    out   valid/ready    written, pixel_col, pixel_row, depth_value, depth_valid
//   cfg       in    cfg_we         cfg_index, cfg_wdata (no read-back)
//
// A splat transaction holds the front end through the accepting cycle, 12 multiply and
// accumulate steps on one shared multiplier, a start state, a wait on the 49-bit dividers
// (the square root is done first) and a push state. A read transaction passes only the
// idle and push states; the depth store takes each command through pop, update and result
// handoff, and pops the next only once the result is taken. After reset a clearing pass
// empties all 307200 entries of the store; request.ready stays low meanwhile.
// A two-entry queue and the result register let either side stall on its own.
module point_cloud_depth_splat (
	input  logic                         clk,
	input  logic                         arst_n,
	cdsp_in_if.sink                      request,
	cdsp_out_if.source                   result,
	input  logic                         cfg_we,
	input  logic [cdsp_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [63:0]                  cfg_wdata
);
	import cdsp_pkg::*;

	cmd_t push_cmd, pop_cmd;
	logic push, pop, fifo_full, fifo_empty, clr_busy;

	cdsp_front u_front (
		.clk, .arst_n, .request,
		.cfg_we, .cfg_index, .cfg_wdata,
		.clr_busy, .fifo_full, .push, .cmd(push_cmd)
	);

	cdsp_fifo u_fifo (
		.clk, .arst_n,
		.push, .din(push_cmd), .full(fifo_full),
		.pop, .dout(pop_cmd), .empty(fifo_empty)
	);

	cdsp_back u_back (
		.clk, .arst_n,
		.fifo_empty, .cmd(pop_cmd), .pop, .clr_busy, .result
	);
endmodule
